// ===== hdl/tqsc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the textured quad scissor clip: item record, register map
// and pipeline sizes. No dependencies.
package tqsc_pkg;

  localparam int DIV_STEPS = 16;
  localparam int LANES = 4;
  localparam logic [16:0] TEX_ONE = 17'd65536;

  typedef enum logic [2:0] {
    REG_CLIP_ENABLE = 3'd0,
    REG_CLIP_LEFT   = 3'd1,
    REG_CLIP_TOP    = 3'd2,
    REG_CLIP_WIDTH  = 3'd3,
    REG_CLIP_HEIGHT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [31:0]        texture;
    logic [31:0]        tint;
    logic signed [31:0] entity;
    logic               clip;
  } item_t;

endpackage

// ===== hdl/textured_quad_scissor_clip.sv =====
`timescale 1ns / 1ps
// Textured rectangle scissor clip with texture coordinate trim.
// Depends on tqsc_pkg.
//
// Channel   Dir  Bits  Contents
// s_axis    in   160   rect_left, rect_top, rect_width, rect_height,
//                      texture_handle, tint_rgba, entity_tag
// m_axis    out  232   out_left .. out_entity
// apb       in   32    clip_enable, clip_left, clip_top, clip_width, clip_height
//
// One transfer per cycle is accepted unless the master side stalls; the 16 stages of
// the restoring dividers, one quotient bit each, sit before the output register.
// Reset clears the configuration registers and all stage valid bits.
// A stall on the master side freezes the whole pipeline; dropped items
// leave bubbles.
module textured_quad_scissor_clip (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rect_left[15:0], rect_top[31:16], rect_width[46:32], rect_height[61:47],
  // texture_handle[93:62], tint_rgba[125:94], entity_tag[157:126], zeros
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_left, out_top, out_width, out_height, tex_s_start, tex_t_start,
  // tex_s_end, tex_t_end, out_texture, out_tint, out_entity, zeros
  output logic [231:0] m_axis_tdata
);

  localparam int DS  = tqsc_pkg::DIV_STEPS;
  localparam int NL  = tqsc_pkg::LANES;
  localparam int LST = DS + 2;

  logic               clip_enable;
  logic signed [15:0] clip_left;
  logic signed [15:0] clip_top;
  logic [14:0]        clip_width;
  logic [14:0]        clip_height;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= 1'b0;
      clip_left   <= '0;
      clip_top    <= '0;
      clip_width  <= '0;
      clip_height <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        tqsc_pkg::REG_CLIP_ENABLE: clip_enable <= pwdata[0];
        tqsc_pkg::REG_CLIP_LEFT:   clip_left   <= pwdata[15:0];
        tqsc_pkg::REG_CLIP_TOP:    clip_top    <= pwdata[15:0];
        tqsc_pkg::REG_CLIP_WIDTH:  clip_width  <= pwdata[14:0];
        tqsc_pkg::REG_CLIP_HEIGHT: clip_height <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tqsc_pkg::REG_CLIP_ENABLE: prdata = {31'd0, clip_enable};
      tqsc_pkg::REG_CLIP_LEFT:   prdata = {{16{clip_left[15]}}, clip_left};
      tqsc_pkg::REG_CLIP_TOP:    prdata = {{16{clip_top[15]}}, clip_top};
      tqsc_pkg::REG_CLIP_WIDTH:  prdata = {17'd0, clip_width};
      tqsc_pkg::REG_CLIP_HEIGHT: prdata = {17'd0, clip_height};
      default:                   prdata = '0;
    endcase
  end

  logic en;
  logic           vld [0:LST];
  tqsc_pkg::item_t itm [0:LST-1];
  logic [14:0]    dw  [0:LST-1];
  logic [14:0]    dh  [0:LST-1];
  logic [14:0]    rem [0:LST-1][0:NL-1];
  logic [DS-1:0]  quo [0:LST-1][0:NL-1];

  assign en            = !vld[LST] || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 0: input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm[0].left    <= s_axis_tdata[15:0];
      itm[0].top     <= s_axis_tdata[31:16];
      itm[0].width   <= s_axis_tdata[46:32];
      itm[0].height  <= s_axis_tdata[61:47];
      itm[0].texture <= s_axis_tdata[93:62];
      itm[0].tint    <= s_axis_tdata[125:94];
      itm[0].entity  <= s_axis_tdata[157:126];
      itm[0].clip    <= clip_enable;
      dw[0]          <= s_axis_tdata[46:32];
      dh[0]          <= s_axis_tdata[61:47];
      for (int l = 0; l < NL; l++) begin
        rem[0][l] <= '0;
        quo[0][l] <= '0;
      end
    end
  end

  // Stage 1: intersection, drop decision and divider numerators.
  logic signed [17:0] x0, y0, rgt, bot, crgt, cbot, nx, ny, nr, nb, ow, oh;
  logic               keep;
  tqsc_pkg::item_t    itm1;

  always_comb begin
    x0   = 18'(itm[0].left);
    y0   = 18'(itm[0].top);
    rgt  = x0 + $signed({3'd0, itm[0].width});
    bot  = y0 + $signed({3'd0, itm[0].height});
    crgt = 18'(clip_left) + $signed({3'd0, clip_width});
    cbot = 18'(clip_top) + $signed({3'd0, clip_height});
    nx   = (x0 > 18'(clip_left)) ? x0 : 18'(clip_left);
    ny   = (y0 > 18'(clip_top)) ? y0 : 18'(clip_top);
    nr   = (rgt < crgt) ? rgt : crgt;
    nb   = (bot < cbot) ? bot : cbot;
    ow   = nr - nx;
    oh   = nb - ny;
    itm1 = itm[0];
    keep = itm[0].texture != 32'd0;
    if (itm[0].clip) begin
      keep        = keep && (ow > 18'sd0) && (oh > 18'sd0);
      itm1.left   = nx[15:0];
      itm1.top    = ny[15:0];
      itm1.width  = ow[14:0];
      itm1.height = oh[14:0];
    end
  end

  logic signed [17:0] cut0, cut1, cut2, cut3;
  assign cut0 = nx - x0;
  assign cut1 = ny - y0;
  assign cut2 = rgt - nr;
  assign cut3 = bot - nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[1] <= 1'b0;
    end else if (en) begin
      vld[1] <= vld[0] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm[1]    <= itm1;
      dw[1]     <= dw[0];
      dh[1]     <= dh[0];
      rem[1][0] <= cut0[14:0];
      rem[1][1] <= cut1[14:0];
      rem[1][2] <= cut2[14:0];
      rem[1][3] <= cut3[14:0];
      for (int l = 0; l < NL; l++) begin
        quo[1][l] <= '0;
      end
    end
  end

  // Stages 2 .. DS+1: one quotient bit per lane per stage.
  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [14:0]   rn [0:NL-1];
    logic [DS-1:0] qn [0:NL-1];

    always_comb begin
      logic [14:0] d;
      logic [15:0] lo;
      logic [15:0] r;
      for (int l = 0; l < NL; l++) begin
        d  = (l % 2 == 0) ? dw[j+1] : dh[j+1];
        lo = {2'b00, d[14:1]};
        r  = {rem[j+1][l], lo[DS-1-j]};
        if (r >= {1'b0, d}) begin
          rn[l] = 15'(r - {1'b0, d});
          qn[l] = {quo[j+1][l][DS-2:0], 1'b1};
        end else begin
          rn[l] = r[14:0];
          qn[l] = {quo[j+1][l][DS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+2] <= 1'b0;
      end else if (en) begin
        vld[j+2] <= vld[j+1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itm[j+2] <= itm[j+1];
        dw[j+2]  <= dw[j+1];
        dh[j+2]  <= dh[j+1];
        for (int l = 0; l < NL; l++) begin
          rem[j+2][l] <= rn[l];
          quo[j+2][l] <= qn[l];
        end
      end
    end
  end

  // Output register.
  tqsc_pkg::item_t ito;
  logic [16:0] s0, t0, s1, t1;
  logic [16:0] s0n, t0n, s1n, t1n;
  tqsc_pkg::item_t itl;

  assign itl = itm[LST-1];

  always_comb begin
    if (itl.clip) begin
      s0n = {1'b0, quo[LST-1][0]};
      t0n = {1'b0, quo[LST-1][1]};
      s1n = tqsc_pkg::TEX_ONE - {1'b0, quo[LST-1][2]};
      t1n = tqsc_pkg::TEX_ONE - {1'b0, quo[LST-1][3]};
    end else begin
      s0n = '0;
      t0n = '0;
      s1n = tqsc_pkg::TEX_ONE;
      t1n = tqsc_pkg::TEX_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[LST] <= 1'b0;
    end else if (en) begin
      vld[LST] <= vld[LST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ito <= itl;
      s0  <= s0n;
      t0  <= t0n;
      s1  <= s1n;
      t1  <= t1n;
    end
  end

  assign m_axis_tvalid = vld[LST];
  assign m_axis_tdata  = {6'd0, ito.entity, ito.tint, ito.texture, t1, s1, t0, s0,
                          ito.height, ito.width, ito.top, ito.left};

  a_drop_null: assert property (@(posedge clk) disable iff (rst)
    vld[0] && en && itm[0].texture == 32'd0 |=> !vld[1])
    else $error("item without texture entered the pipeline");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> s0 <= tqsc_pkg::TEX_ONE && s1 <= tqsc_pkg::TEX_ONE
                      && ito.texture != 32'd0)
    else $error("result out of range");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for textured_quad_scissor_clip: directed rows and
// random rectangles, each checked against a clip predictor. Depends on tqsc_pkg.
module tb;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0] width;
    logic [14:0] height;
    logic [31:0] texture;
    logic [31:0] tint;
    logic [31:0] entity;
  } rect_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [14:0] width;
    logic [14:0] height;
    logic [16:0] s0;
    logic [16:0] t0;
    logic [16:0] s1;
    logic [16:0] t1;
    logic [31:0] texture;
    logic [31:0] tint;
    logic [31:0] entity;
  } quad_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [231:0] m_axis_tdata;

  textured_quad_scissor_clip dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  logic en_q;
  int signed cl_q, ct_q, cw_q, ch_q;
  quad_t quads_due[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;

  function automatic logic [16:0] trim_frac(int signed num, int signed den);
    longint unsigned n, d;
    n = longint'(num);
    d = longint'(den);
    if (d == 0) return 0;
    return 17'((n * 65536 + d / 2) / d);
  endfunction

  function automatic bit clip_rect(rect_t r, output quad_t q);
    int signed x, y, w, h, rt, bt, nx, ny, nr, nb, ow, oh;
    x = r.left; y = r.top; w = r.width; h = r.height;
    q.left = r.left; q.top = r.top; q.width = r.width; q.height = r.height;
    q.s0 = 0; q.t0 = 0; q.s1 = tqsc_pkg::TEX_ONE; q.t1 = tqsc_pkg::TEX_ONE;
    q.texture = r.texture; q.tint = r.tint; q.entity = r.entity;
    if (r.texture == 0) return 0;
    if (en_q) begin
      rt = x + w; bt = y + h;
      nx = x > cl_q ? x : cl_q;
      ny = y > ct_q ? y : ct_q;
      nr = rt < cl_q + cw_q ? rt : cl_q + cw_q;
      nb = bt < ct_q + ch_q ? bt : ct_q + ch_q;
      ow = nr - nx; oh = nb - ny;
      if (ow <= 0 || oh <= 0) return 0;
      q.s0 = trim_frac(nx - x, w);
      q.t0 = trim_frac(ny - y, h);
      q.s1 = tqsc_pkg::TEX_ONE - trim_frac(rt - nr, w);
      q.t1 = tqsc_pkg::TEX_ONE - trim_frac(bt - nb, h);
      q.left = 16'(nx); q.top = 16'(ny); q.width = 15'(ow); q.height = 15'(oh);
    end
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    quad_t g, e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        {g.entity, g.tint, g.texture, g.t1, g.s1, g.t0, g.s0,
         g.height, g.width, g.top, g.left} = m_axis_tdata[225:0];
        if (quads_due.size() == 0) begin
          report_mismatch("unexpected transfer", 0, 0);
        end else begin
          e = quads_due.pop_front();
          if (g.left !== e.left) report_mismatch("left", g.left, e.left);
          if (g.top !== e.top) report_mismatch("top", g.top, e.top);
          if (g.width !== e.width) report_mismatch("width", g.width, e.width);
          if (g.height !== e.height) report_mismatch("height", g.height, e.height);
          if (g.s0 !== e.s0) report_mismatch("s_start", g.s0, e.s0);
          if (g.t0 !== e.t0) report_mismatch("t_start", g.t0, e.t0);
          if (g.s1 !== e.s1) report_mismatch("s_end", g.s1, e.s1);
          if (g.t1 !== e.t1) report_mismatch("t_end", g.t1, e.t1);
          if (g.texture !== e.texture) report_mismatch("texture", g.texture, e.texture);
          if (g.tint !== e.tint) report_mismatch("tint", g.tint, e.tint);
          if (g.entity !== e.entity) report_mismatch("entity", g.entity, e.entity);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic reg_write(tqsc_pkg::reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      tqsc_pkg::REG_CLIP_ENABLE: en_q = val[0];
      tqsc_pkg::REG_CLIP_LEFT: cl_q = $signed(val[15:0]);
      tqsc_pkg::REG_CLIP_TOP: ct_q = $signed(val[15:0]);
      tqsc_pkg::REG_CLIP_WIDTH: cw_q = val[14:0];
      tqsc_pkg::REG_CLIP_HEIGHT: ch_q = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_clip(bit en, int l, int t, int w, int h);
    reg_write(tqsc_pkg::REG_CLIP_ENABLE, en);
    reg_write(tqsc_pkg::REG_CLIP_LEFT, l);
    reg_write(tqsc_pkg::REG_CLIP_TOP, t);
    reg_write(tqsc_pkg::REG_CLIP_WIDTH, w);
    reg_write(tqsc_pkg::REG_CLIP_HEIGHT, h);
  endtask

  task automatic send_rect(rect_t r, bit check_table, quad_t want, bit want_out);
    quad_t q;
    bit has;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b0, r.entity, r.tint, r.texture, r.height, r.width, r.top, r.left};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    has = clip_rect(r, q);
    if (check_table && (has !== want_out || (has && q !== want)))
      report_mismatch("predictor vs table", has, want_out);
    if (has) quads_due.push_back(q);
  endtask

  task automatic drain();
    int n;
    n = 0;
    s_axis_tvalid <= 0;
    while (quads_due.size() != 0) @(posedge clk);
    while (n < 40) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic rect_t rand_rect(bit near);
    rect_t r;
    r.left = near ? 16'($signed($urandom_range(1200)) - 600) : 16'($urandom);
    r.top = near ? 16'($signed($urandom_range(1200)) - 600) : 16'($urandom);
    r.width = near ? 15'($urandom_range(800)) : 15'($urandom);
    r.height = near ? 15'($urandom_range(800)) : 15'($urandom);
    r.texture = ($urandom_range(15) == 0) ? 0 : $urandom;
    r.tint = $urandom;
    r.entity = $urandom;
    return r;
  endfunction

  initial begin
    rect_t dir_rects[8];
    quad_t dir_want[8];
    bit dir_out[8];
    rect_t r;
    quad_t none;
    int ph;
    none = '{default: 0};
    en_q = 0; cl_q = 0; ct_q = 0; cw_q = 0; ch_q = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Pass-through after reset, with extreme fields; a null texture is dropped.
    dir_rects[0] = '{16'sh8000, 16'sh7fff, 15'h7fff, 15'h0, 32'hffffffff,
                     32'h0, 32'h80000000};
    dir_want[0] = '{16'h8000, 16'h7fff, 15'h7fff, 15'h0, 0, 0,
                    tqsc_pkg::TEX_ONE, tqsc_pkg::TEX_ONE,
                    32'hffffffff, 32'h0, 32'h80000000};
    dir_out[0] = 1;
    dir_rects[1] = '{16'sh7fff, 16'sh8000, 15'h0, 15'h7fff, 32'h1,
                     32'hffffffff, 32'h7fffffff};
    dir_want[1] = '{16'h7fff, 16'h8000, 15'h0, 15'h7fff, 0, 0,
                    tqsc_pkg::TEX_ONE, tqsc_pkg::TEX_ONE,
                    32'h1, 32'hffffffff, 32'h7fffffff};
    dir_out[1] = 1;
    dir_rects[2] = '{16'sh10, 16'sh20, 15'h30, 15'h40, 32'h0, 32'h5, 32'h6};
    dir_out[2] = 0;
    dir_want[2] = none;
    for (int i = 0; i < 3; i++) send_rect(dir_rects[i], 1, dir_want[i], dir_out[i]);
    drain();

    // Zero-size clip rectangle drops everything.
    set_clip(1, 0, 0, 0, 0);
    dir_rects[3] = '{16'sh0, 16'sh0, 15'h100, 15'h100, 32'h9, 32'h1, 32'h2};
    send_rect(dir_rects[3], 1, none, 0);
    drain();

    // Partial clips, fully inside, disjoint, zero-size rectangle, extremes.
    set_clip(1, 16'h0040, 16'h0040, 15'h0100, 15'h0100);
    dir_rects[0] = '{16'sh0, 16'sh0, 15'h0100, 15'h0100, 32'h3, 32'h4, 32'h5};
    dir_rects[1] = '{16'sh0050, 16'sh0050, 15'h0010, 15'h0010, 32'h3, 32'h4, 32'h5};
    dir_rects[2] = '{16'sh1000, 16'sh0, 15'h0010, 15'h0010, 32'h3, 32'h4, 32'h5};
    dir_rects[3] = '{16'sh0050, 16'sh0050, 15'h0, 15'h0010, 32'h3, 32'h4, 32'h5};
    dir_rects[4] = '{16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 32'h3, 32'h4, 32'h5};
    dir_rects[5] = '{16'sh0030, 16'sh0100, 15'h0033, 15'h0077, 32'h3, 32'h4, 32'h5};
    for (int i = 0; i < 6; i++) send_rect(dir_rects[i], 0, none, 0);
    drain();
    set_clip(1, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
    dir_rects[6] = '{16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 32'h3, 32'h4, 32'h5};
    dir_rects[7] = '{16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 32'h3, 32'h4, 32'h5};
    send_rect(dir_rects[6], 0, none, 0);
    send_rect(dir_rects[7], 0, none, 0);
    drain();

    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 71; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 71; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      if (ph == 11) set_clip(0, 0, 0, 0, 0);
      else set_clip(ph != 5, $signed($urandom_range(800)) - 400,
                    $signed($urandom_range(800)) - 400,
                    (ph == 3) ? 32'h7fff : $urandom_range(900),
                    (ph == 3) ? 32'h7fff : $urandom_range(900));
      for (int k = 0; k < 138; k++) begin
        r = rand_rect($urandom_range(9) < 8);
        send_rect(r, 0, none, 0);
      end
      drain();
    end
    recv_stall = 0;
    drain();
    if (errors == 0 && quads_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
